@@ sv/emr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// emr_pkg
// Shared types, widths and helpers for the midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
package emr_pkg;

    localparam int MUL_A_W = 16;
    localparam int MUL_B_W = 20;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 38;
    localparam int DEC_W   = 36;
    localparam int GRAD_W  = 25;

    localparam logic [1:0] CFG_CENTER_X = 2'd0;
    localparam logic [1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [1:0] CFG_RADIUS_X = 2'd2;
    localparam logic [1:0] CFG_RADIUS_Y = 2'd3;

    localparam logic [1:0] QUAD_LAST = 2'd3;

    typedef enum logic [15:0] {
        ST_IDLE   = 16'h0001,
        ST_AA     = 16'h0002,
        ST_BB     = 16'h0004,
        ST_DISP   = 16'h0008,
        ST_SQX    = 16'h0010,
        ST_BBS    = 16'h0020,
        ST_SQY    = 16'h0040,
        ST_AAT    = 16'h0080,
        ST_AABB   = 16'h0100,
        ST_INIT1  = 16'h0200,
        ST_INIT2  = 16'h0400,
        ST_DIV4   = 16'h0800,
        ST_UPD1   = 16'h1000,
        ST_UPD2   = 16'h2000,
        ST_SETTLE = 16'h4000,
        ST_EMIT   = 16'h8000
    } emr_state_t;

    typedef struct packed {
        logic       load;
        logic [1:0] quadrant;
        logic       fin;
    } emr_emit_t;

    // Quarter-unit value divided by four, rounding toward zero.
    function automatic logic [DEC_W-1:0] trunc_div4(input logic signed [ACC_W-1:0] n);
        logic signed [ACC_W-1:0] biased;
        logic signed [ACC_W-1:0] q;
        biased = n + (n[ACC_W-1] ? ACC_W'(3) : ACC_W'(0));
        q      = biased >>> 2;
        return q[DEC_W-1:0];
    endfunction

endpackage
`default_nettype wire

@@ sv/emr_mul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// emr_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module emr_mul
    import emr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic [MUL_A_W-1:0] op_a,
    input  wire logic [MUL_B_W-1:0] op_b,
    output logic      [MUL_P_W-1:0] prod
);

    logic [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

@@ sv/emr_out.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// emr_out
// Mirrors the current point into one quadrant and holds the pixel beat in an
// output register until the consumer takes it.
// ----------------------------------------------------------------------------
module emr_out
    import emr_pkg::*;
#(
    parameter int FRAME_WIDTH  = 256,
    parameter int FRAME_HEIGHT = 128
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire emr_emit_t          emit,
    input  wire logic [7:0]         center_x,
    input  wire logic [6:0]         center_y,
    input  wire logic [8:0]         offset_x,
    input  wire logic [7:0]         offset_y,
    output logic                    slot_free,
    output logic                    pixel_valid,
    input  wire logic               pixel_ready,
    output logic signed [9:0]       pixel_x,
    output logic signed [8:0]       pixel_y,
    output logic [1:0]              quadrant,
    output logic                    inside_res,
    output logic                    last,
    output logic                    final_res
);

    logic [10:0]       px;
    logic [9:0]        py;
    logic              in_frame;
    logic              valid_reg;
    logic signed [9:0] pixel_x_reg;
    logic signed [8:0] pixel_y_reg;
    logic [1:0]        quadrant_reg;
    logic              inside_reg;
    logic              last_reg;
    logic              final_reg;

    always_comb
    begin
        px = emit.quadrant[0] ? ({3'b000, center_x} - {2'b00, offset_x})
                              : ({3'b000, center_x} + {2'b00, offset_x});
        py = emit.quadrant[1] ? ({3'b000, center_y} - {2'b00, offset_y})
                              : ({3'b000, center_y} + {2'b00, offset_y});
        in_frame = !px[10] && (32'(px[9:0]) < 32'(FRAME_WIDTH))
                && !py[9] && (32'(py[8:0]) < 32'(FRAME_HEIGHT));
    end

    assign slot_free = !valid_reg || pixel_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (emit.load)
        begin
            valid_reg <= 1'b1;
        end
        else if (pixel_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.load)
        begin
            pixel_x_reg  <= $signed(px[9:0]);
            pixel_y_reg  <= $signed(py[8:0]);
            quadrant_reg <= emit.quadrant;
            inside_reg   <= in_frame;
            last_reg     <= (emit.quadrant == QUAD_LAST);
            final_reg    <= emit.fin;
        end
    end

    assign pixel_valid = valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign quadrant    = quadrant_reg;
    assign inside_res  = inside_reg;
    assign last        = last_reg;
    assign final_res   = final_reg;

endmodule
`default_nettype wire

@@ sv/midpoint_ellipse_rasterizer_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_core
// Midpoint ellipse walker: a sequencer around one shared multiplier forms the
// squared radii and the initial decisions, and emits four mirrored pixels.
// ----------------------------------------------------------------------------
// A restart beat begins a new ellipse at (0, radius_y); each later step beat
// advances one point and yields four pixel beats, quadrants 0 to 3, the last
// flagged. Step beats are not accepted while a point is in work, and the
// first point of region two takes longer than the others, because every product
// passes one at a time through the single registered multiplier and the four
// pixels leave through one output register; a step after the final point is
// accepted and yields nothing. Stalls on the pixel channel hold the walker in
// its emit state. The geometry registers may be rewritten between beats and
// take effect on the next one.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_core
    import emr_pkg::*;
#(
    parameter int FRAME_WIDTH  = 256,
    parameter int FRAME_HEIGHT = 128
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [7:0]   cfg_data,
    input  wire logic         step_valid,
    output logic              step_ready,
    input  wire logic         restart,
    output logic              pixel_valid,
    input  wire logic         pixel_ready,
    output logic signed [9:0] pixel_x,
    output logic signed [8:0] pixel_y,
    output logic [1:0]        quadrant,
    output logic              inside_res,
    output logic              last,
    output logic              final_res
);

    emr_state_t state_reg;
    emr_state_t state_next;

    logic [7:0]                cx_reg;
    logic [6:0]                cy_reg;
    logic [7:0]                rx_reg;
    logic [6:0]                ry_reg;
    logic [8:0]                ox_reg;
    logic [7:0]                oy_reg;
    logic signed [GRAD_W-1:0]  gx_reg;
    logic signed [GRAD_W-1:0]  gy_reg;
    logic signed [DEC_W-1:0]   dec_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [15:0]               aa_reg;
    logic [13:0]               bb_reg;
    logic                      region_two_reg;
    logic                      walk_done_reg;
    logic                      first_pending_reg;
    logic                      fin_reg;
    logic                      restart_reg;
    logic                      branch_reg;
    logic [1:0]                q_reg;

    logic [MUL_A_W-1:0]        mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic [MUL_P_W-1:0]        mul_prod;
    logic [9:0]                sx;
    logic [7:0]                ty;
    logic [DEC_W-1:0]          dec_add;
    logic signed [GRAD_W-1:0]  g_plus;
    logic signed [GRAD_W-1:0]  g_minus;
    logic [DEC_W-1:0]          dec_upd;
    logic [GRAD_W-1:0]         two_aa;
    logic [GRAD_W-1:0]         two_bb;
    logic                      dec_pos;
    logic                      slot_free;
    emr_emit_t                 emit;

    assign cfg_ready  = 1'b1;
    assign step_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        sx      = {ox_reg, 1'b1};
        ty      = (oy_reg == 8'd0) ? 8'd1 : (oy_reg - 8'd1);
        two_aa  = {8'b0, aa_reg, 1'b0};
        two_bb  = {10'b0, bb_reg, 1'b0};
        dec_pos = !dec_reg[DEC_W-1] && (dec_reg != '0);
        dec_add = region_two_reg ? {20'b0, aa_reg} : {22'b0, bb_reg};
        g_plus  = (region_two_reg && branch_reg) ? '0 : gx_reg;
        g_minus = (!region_two_reg && branch_reg) ? '0 : gy_reg;
        dec_upd = dec_reg + dec_add
                + {{(DEC_W-GRAD_W){g_plus[GRAD_W-1]}}, g_plus}
                - {{(DEC_W-GRAD_W){g_minus[GRAD_W-1]}}, g_minus};
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_AA:
            begin
                mul_a = {8'b0, rx_reg};
                mul_b = {12'b0, rx_reg};
            end
            ST_BB:
            begin
                mul_a = {9'b0, ry_reg};
                mul_b = {13'b0, ry_reg};
            end
            ST_DISP:
            begin
                mul_a = aa_reg;
                mul_b = {13'b0, ry_reg};
            end
            ST_SQX:
            begin
                mul_a = {6'b0, sx};
                mul_b = {10'b0, sx};
            end
            ST_BBS:
            begin
                mul_a = {2'b0, bb_reg};
                mul_b = mul_prod[MUL_B_W-1:0];
            end
            ST_SQY:
            begin
                mul_a = {8'b0, ty};
                mul_b = {12'b0, ty};
            end
            ST_AAT:
            begin
                mul_a = aa_reg;
                mul_b = mul_prod[MUL_B_W-1:0];
            end
            ST_AABB:
            begin
                mul_a = aa_reg;
                mul_b = {6'b0, bb_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    emr_mul u_mul
    (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    always_comb
    begin
        emit.load     = (state_reg == ST_EMIT) && slot_free;
        emit.quadrant = q_reg;
        emit.fin      = fin_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (step_valid && (restart || !walk_done_reg))
                begin
                    state_next = ST_AA;
                end
            end
            ST_AA:    state_next = ST_BB;
            ST_BB:    state_next = ST_DISP;
            ST_DISP:
            begin
                if (restart_reg)
                begin
                    state_next = ST_INIT1;
                end
                else if (first_pending_reg)
                begin
                    state_next = ST_SQX;
                end
                else
                begin
                    state_next = ST_UPD1;
                end
            end
            ST_SQX:   state_next = ST_BBS;
            ST_BBS:   state_next = ST_SQY;
            ST_SQY:   state_next = ST_AAT;
            ST_AAT:   state_next = ST_AABB;
            ST_AABB:  state_next = ST_INIT2;
            ST_INIT1: state_next = ST_DIV4;
            ST_INIT2: state_next = ST_DIV4;
            ST_DIV4:  state_next = restart_reg ? ST_SETTLE : ST_UPD1;
            ST_UPD1:  state_next = ST_UPD2;
            ST_UPD2:  state_next = ST_SETTLE;
            ST_SETTLE: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (emit.load && (q_reg == QUAD_LAST))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            cx_reg            <= '0;
            cy_reg            <= '0;
            rx_reg            <= '0;
            ry_reg            <= '0;
            ox_reg            <= '0;
            oy_reg            <= '0;
            gx_reg            <= '0;
            gy_reg            <= '0;
            dec_reg           <= '0;
            region_two_reg    <= 1'b0;
            walk_done_reg     <= 1'b1;
            first_pending_reg <= 1'b0;
            fin_reg           <= 1'b0;
            restart_reg       <= 1'b0;
            branch_reg        <= 1'b0;
            q_reg             <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CENTER_X: cx_reg <= cfg_data;
                    CFG_CENTER_Y: cy_reg <= cfg_data[6:0];
                    CFG_RADIUS_X: rx_reg <= cfg_data;
                    CFG_RADIUS_Y: ry_reg <= cfg_data[6:0];
                    default:      cx_reg <= cx_reg;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (step_valid)
                    begin
                        restart_reg <= restart;
                    end
                end
                ST_INIT1:
                begin
                    ox_reg            <= '0;
                    oy_reg            <= {1'b0, ry_reg};
                    gx_reg            <= '0;
                    gy_reg            <= {mul_prod[GRAD_W-2:0], 1'b0};
                    region_two_reg    <= 1'b0;
                    first_pending_reg <= 1'b0;
                    walk_done_reg     <= 1'b0;
                end
                ST_INIT2:
                begin
                    first_pending_reg <= 1'b0;
                end
                ST_DIV4:
                begin
                    dec_reg <= trunc_div4(acc_reg);
                end
                ST_UPD1:
                begin
                    if (!region_two_reg)
                    begin
                        ox_reg     <= ox_reg + 9'd1;
                        gx_reg     <= gx_reg + two_bb;
                        branch_reg <= dec_reg[DEC_W-1];
                        if (!dec_reg[DEC_W-1])
                        begin
                            oy_reg <= oy_reg - 8'd1;
                            gy_reg <= gy_reg - two_aa;
                        end
                    end
                    else
                    begin
                        oy_reg     <= oy_reg - 8'd1;
                        gy_reg     <= gy_reg - two_aa;
                        branch_reg <= dec_pos;
                        if (!dec_pos)
                        begin
                            ox_reg <= ox_reg + 9'd1;
                            gx_reg <= gx_reg + two_bb;
                        end
                    end
                end
                ST_UPD2:
                begin
                    dec_reg <= dec_upd;
                end
                ST_SETTLE:
                begin
                    q_reg <= '0;
                    if (!region_two_reg && (gx_reg < gy_reg))
                    begin
                        walk_done_reg <= 1'b0;
                        fin_reg       <= 1'b0;
                    end
                    else
                    begin
                        if (!region_two_reg)
                        begin
                            region_two_reg    <= 1'b1;
                            first_pending_reg <= 1'b1;
                        end
                        walk_done_reg <= (oy_reg == 8'd0);
                        fin_reg       <= (oy_reg == 8'd0);
                    end
                end
                ST_EMIT:
                begin
                    if (emit.load)
                    begin
                        q_reg <= q_reg + 2'd1;
                    end
                end
                default:
                begin
                    q_reg <= q_reg;
                end
            endcase
        end
    end

    // Squared radii and the quarter-unit accumulator need no reset.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_BB:    aa_reg  <= mul_prod[15:0];
            ST_DISP:  bb_reg  <= mul_prod[13:0];
            ST_SQY:   acc_reg <= ACC_W'(mul_prod);
            ST_AABB:  acc_reg <= acc_reg + {mul_prod, 2'b00};
            ST_INIT2: acc_reg <= acc_reg - {mul_prod, 2'b00} + ACC_W'(2);
            ST_INIT1:
            begin
                acc_reg <= {22'b0, bb_reg, 2'b00}
                         - {13'b0, mul_prod[22:0], 2'b00}
                         + {22'b0, aa_reg}
                         + ACC_W'(2);
            end
            default:  acc_reg <= acc_reg;
        endcase
    end

    emr_out #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_out
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .emit        (emit),
        .center_x    (cx_reg),
        .center_y    (cy_reg),
        .offset_x    (ox_reg),
        .offset_y    (oy_reg),
        .slot_free   (slot_free),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .quadrant    (quadrant),
        .inside_res  (inside_res),
        .last        (last),
        .final_res   (final_res)
    );

`ifndef NO_ASSERTIONS
    a_restart_starts: assert property (@(posedge clk) disable iff (!rst_n)
        step_valid && step_ready && restart |=> state_reg == ST_AA)
        else $error("A restart beat did not start the multiplier sequence.");

    a_done_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
        step_valid && step_ready && !restart && walk_done_reg |=> state_reg == ST_IDLE)
        else $error("A step after the final point started work.");

    a_pending_in_r2: assert property (@(posedge clk) disable iff (!rst_n)
        first_pending_reg |-> region_two_reg)
        else $error("A region two decision is pending outside region two.");

    a_settle_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SETTLE |=> walk_done_reg == fin_reg)
        else $error("The walk end flag disagrees with the final point flag.");
`endif

endmodule
`default_nettype wire
